@@ rtl/core/lfls_pkg.sv @@
// Shared types and constants for the linked free-list stack.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lfls_pkg;

  localparam int unsigned CAP_W    = 10;   // capacity register width
  localparam int unsigned IDX_W    = 32;   // block index width
  localparam int unsigned CNT_OUT_W = 11;  // reported entry count width

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(512);
  localparam logic [IDX_W-1:0] NO_INDEX  = {IDX_W{1'b1}};

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input word and read the node memory
    logic commit;   // apply the operation and load the result register
  } lfls_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/lfls_if.sv @@
// Valid/ready channel interfaces for the request and response words.
// Depends on lfls_pkg for field widths.
`default_nettype none

interface lfls_in_if
  import lfls_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             op;
  logic [IDX_W-1:0] blk_idx;

  modport source (output valid, output op, output blk_idx, input ready);
  modport sink   (input valid, input op, input blk_idx, output ready);
endinterface

interface lfls_out_if
  import lfls_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [IDX_W-1:0]     popped_index;
  logic [CNT_OUT_W-1:0] entry_count;
  logic                 is_empty;

  modport source (output valid, output ok, output popped_index, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input ok, input popped_index, input entry_count,
                  input is_empty, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lfls_ctrl.sv @@
// Sequencing FSM: takes one request word in ST_IDLE, which starts the node
// memory read, then commits in ST_EXEC into the response register once it is free. Uses lfls_pkg.
`default_nettype none

module lfls_ctrl
  import lfls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output lfls_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  always_comb begin
    in_ready       = (state == ST_IDLE);
    cmd.capture    = in_valid && (state == ST_IDLE);
    cmd.commit     = (state == ST_EXEC) && (!out_valid || out_ready);
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // hold here while the previous response is still waiting
        if (cmd.commit) begin
          state_next     = ST_IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lfls_dp.sv @@
// Datapath: node memories, list/recycle heads, bump pointer, count,
// capacity register and the response register. Uses lfls_pkg.
`default_nettype none

module lfls_dp
  import lfls_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lfls_cmd_t            cmd,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CAP_W-1:0]     cfg_wr_data,
  input  wire logic                 in_op,
  input  wire logic [IDX_W-1:0]     in_blk_idx,
  output logic                      ok,
  output logic [IDX_W-1:0]          popped_index,
  output logic [CNT_OUT_W-1:0]      entry_count,
  output logic                      is_empty
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned PW = AW + 1;                  // top bit marks null
  localparam int unsigned BW = $clog2(MAX_NODES + 1);   // holds 0..MAX_NODES
  localparam int unsigned LW = (BW > CAP_W + 1) ? BW : CAP_W + 1;
  localparam logic [PW-1:0] NULL_PTR  = {PW{1'b1}};
  localparam logic [LW-1:0] NODES_EXT = LW'(MAX_NODES);

  logic [IDX_W-1:0] node_value [MAX_NODES];
  logic [PW-1:0]    node_link  [MAX_NODES];

  logic [CAP_W-1:0] capacity;
  logic [PW-1:0]    list_head;
  logic [PW-1:0]    recycle_head;
  logic [BW-1:0]    bump_pointer;
  logic [BW-1:0]    held_count;

  logic             op_q;
  logic [IDX_W-1:0] block_q;
  logic [IDX_W-1:0] rd_value;
  logic [PW-1:0]    rd_link;

  logic [AW-1:0]    rd_addr;
  logic [LW-1:0]    bump_ext;
  logic [LW-1:0]    limit_ext;
  logic             fresh_ok;
  logic             push_recycle;
  logic             push_fresh;
  logic             push_ok;
  logic             pop_ok;
  logic [AW-1:0]    node_sel;
  logic [PW-1:0]    list_head_next;
  logic [BW-1:0]    count_next;
  logic [BW+CNT_OUT_W-1:0] count_wide;

  // pop reads the head node, push reads the recycle head's link
  assign rd_addr = in_op ? list_head[AW-1:0] : recycle_head[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= in_op;
      block_q  <= in_blk_idx;
      rd_value <= node_value[rd_addr];
      rd_link  <= node_link[rd_addr];
    end
  end

  always_comb begin
    bump_ext     = LW'(bump_pointer);
    limit_ext    = LW'({capacity, 1'b0});
    fresh_ok     = (bump_ext < limit_ext) && (bump_ext < NODES_EXT);
    push_recycle = (op_q == OP_PUSH) && !recycle_head[AW];
    push_fresh   = (op_q == OP_PUSH) && recycle_head[AW] && fresh_ok;
    push_ok      = push_recycle || push_fresh;
    pop_ok       = (op_q == OP_POP) && !list_head[AW];

    if (push_recycle)    node_sel = recycle_head[AW-1:0];
    else if (push_fresh) node_sel = bump_pointer[AW-1:0];
    else                 node_sel = list_head[AW-1:0];

    list_head_next = list_head;
    count_next     = held_count;
    if (push_ok) begin
      list_head_next = {1'b0, node_sel};
      count_next     = held_count + BW'(1);
    end else if (pop_ok) begin
      list_head_next = rd_link;
      if (held_count != '0) count_next = held_count - BW'(1);
    end
    count_wide = {{CNT_OUT_W{1'b0}}, count_next};
  end

  // node memory writes
  always_ff @(posedge clk) begin
    if (cmd.commit && push_ok) node_value[node_sel] <= block_q;
    if (cmd.commit && (push_ok || pop_ok)) begin
      node_link[node_sel] <= (op_q == OP_POP) ? recycle_head : list_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAP_RESET;
      list_head    <= NULL_PTR;
      recycle_head <= NULL_PTR;
      bump_pointer <= '0;
      held_count   <= '0;
    end else begin
      if (cfg_wr_en) capacity <= cfg_wr_data;
      if (cmd.commit) begin
        list_head  <= list_head_next;
        held_count <= count_next;
        if (push_recycle) recycle_head <= rd_link;
        if (pop_ok)       recycle_head <= list_head;
        if (push_fresh)   bump_pointer <= bump_pointer + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok           <= push_ok || pop_ok;
      popped_index <= pop_ok ? rd_value : NO_INDEX;
      entry_count  <= count_wide[CNT_OUT_W-1:0];
      is_empty     <= list_head_next[AW];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/linked_free_list_stack.sv @@
// Top level of the linked free-list stack: FSM plus datapath.
// Depends on lfls_pkg, lfls_if, lfls_ctrl and lfls_dp.
//
//   channel  dir  handshake           word fields
//   req      in   valid/ready         op, blk_idx
//   rsp      out  valid/ready         ok, popped_index, entry_count, is_empty
//   cfg      in   cfg_wr_en           cfg_wr_data (capacity)
//
// Each request has a read step, on the node memory at the head (pop) or at
// the recycle head (push), and then a commit step that loads the response.
// The single-port node memory read sets this split; requests are serialized.
// A stalled response holds the next request in its commit step.
// Synchronous reset empties both lists; node memory contents are not cleared.
`default_nettype none

module linked_free_list_stack
  import lfls_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data,
  lfls_in_if.sink               req,
  lfls_out_if.source            rsp
);

  lfls_cmd_t cmd;

  lfls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  lfls_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_op          (req.op),
    .in_blk_idx     (req.blk_idx),
    .ok             (rsp.ok),
    .popped_index   (rsp.popped_index),
    .entry_count    (rsp.entry_count),
    .is_empty       (rsp.is_empty)
  );

endmodule

`default_nettype wire

@@ rtl/core/lfls_checker.sv @@
// Port-level checks for linked_free_list_stack, attached by bind.
// Depends on lfls_pkg and the top level's ports.
`default_nettype none

module lfls_checker
  import lfls_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 req_valid,
  input wire logic                 req_ready,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic                 rsp_ok,
  input wire logic [IDX_W-1:0]     rsp_popped_index,
  input wire logic [CNT_OUT_W-1:0] rsp_entry_count,
  input wire logic                 rsp_is_empty
);

  // reset drops any pending response
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // one request in flight: busy the cycle after a request word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while another is in flight");

  // hold a waiting response word until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable({rsp_ok, rsp_popped_index, rsp_entry_count, rsp_is_empty})))
    else $error("response word changed while waiting");

  // failed step never returns an index
  a_fail_no_index: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ok) |-> (rsp_popped_index == NO_INDEX))
    else $error("failed step returned an index");

  // empty list holds no entries
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_is_empty) |-> (rsp_entry_count == '0))
    else $error("empty flag with nonzero count");

endmodule

bind linked_free_list_stack lfls_checker u_lfls_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_ok           (rsp.ok),
  .rsp_popped_index (rsp.popped_index),
  .rsp_entry_count  (rsp.entry_count),
  .rsp_is_empty     (rsp.is_empty)
);

`default_nettype wire

@@ tb/lfls_result_checker.sv @@
`timescale 1ns / 1ps
// Response checker for the linked free-list stack: watches both channels and the
// capacity write port, predicts each response word and compares it. Needs lfls_pkg, lfls_if.
module lfls_result_checker
  import lfls_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  lfls_in_if               req,
  lfls_out_if              rsp,
  output int               fail_count,
  output int               pending
);

  localparam int unsigned LINK_W = 11;
  localparam logic [LINK_W-1:0] LINK_NONE = {LINK_W{1'b1}};

  typedef struct packed {
    logic                 ok;
    logic [IDX_W-1:0]     popped_index;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 is_empty;
  } stack_result_t;

  // shadow copy of the stack
  logic [IDX_W-1:0]  node_val  [MAX_NODES];
  logic [LINK_W-1:0] node_next [MAX_NODES];
  logic [LINK_W-1:0] top_node;
  logic [LINK_W-1:0] spare_head;
  logic [LINK_W-1:0] fresh_ptr;
  logic [LINK_W-1:0] held;
  logic [CAP_W-1:0]  cap_reg;

  stack_result_t expected_words[$];
  int            mismatches;

  function automatic stack_result_t model_request(input logic op, input logic [IDX_W-1:0] idx);
    stack_result_t     r;
    logic [LINK_W-1:0] node_lim;
    logic [LINK_W-1:0] n;
    // node limit is twice the capacity, clamped to the node memory
    node_lim = {cap_reg, 1'b0};
    if (node_lim > MAX_NODES) node_lim = LINK_W'(MAX_NODES);
    r.ok = 1'b0;
    r.popped_index = NO_INDEX;
    if (op == OP_PUSH) begin
      n = LINK_NONE;
      if (spare_head < MAX_NODES) begin
        n = spare_head;
        spare_head = node_next[n];
      end else if (fresh_ptr < node_lim) begin
        n = fresh_ptr;
        fresh_ptr = fresh_ptr + 1'b1;
      end
      if (n != LINK_NONE) begin
        node_val[n] = idx;
        node_next[n] = top_node;
        top_node = n;
        held = held + 1'b1;
        r.ok = 1'b1;
      end
    end else if (top_node < MAX_NODES) begin
      n = top_node;
      top_node = node_next[n];
      r.popped_index = node_val[n];
      node_next[n] = spare_head;
      spare_head = n;
      if (held != 0) held = held - 1'b1;
      r.ok = 1'b1;
    end
    r.entry_count = held;
    r.is_empty = !(top_node < MAX_NODES);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input stack_result_t want,
                               input stack_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected ok=%0b idx=%h cnt=%0d empty=%0b,",
               $realtime, what, want.ok, want.popped_index, want.entry_count, want.is_empty,
               " got ok=%0b idx=%h cnt=%0d empty=%0b",
               got.ok, got.popped_index, got.entry_count, got.is_empty);
  endtask

  initial begin
    mismatches = 0;
  end

  always @(posedge clk) begin
    stack_result_t got;
    stack_result_t want;
    if (rst) begin
      top_node = LINK_NONE;
      spare_head = LINK_NONE;
      fresh_ptr = '0;
      held = '0;
      cap_reg = CAP_RESET;
      expected_words.delete();
    end else begin
      // check the outgoing word before predicting the incoming one
      if (rsp.valid && rsp.ready) begin
        got.ok = rsp.ok;
        got.popped_index = rsp.popped_index;
        got.entry_count = rsp.entry_count;
        got.is_empty = rsp.is_empty;
        if (expected_words.size() == 0) begin
          flag_mismatch("response word with none expected", '0, got);
        end else begin
          want = expected_words.pop_front();
          if (got.ok !== want.ok || got.popped_index !== want.popped_index ||
              got.entry_count !== want.entry_count || got.is_empty !== want.is_empty)
            flag_mismatch("response word mismatch", want, got);
        end
      end
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      if (req.valid && req.ready)
        expected_words.push_back(model_request(req.op, req.blk_idx));
    end
    fail_count <= mismatches;
    pending <= expected_words.size();
  end

endmodule

@@ tb/tb_linked_free_list_stack.sv @@
`timescale 1ns / 1ps
// Top of the linked free-list stack testbench: clock, reset, request and capacity
// stimulus, response back-pressure and the verdict. Needs lfls_pkg, lfls_if, lfls_result_checker.
module tb_linked_free_list_stack;
  import lfls_pkg::*;

  localparam int unsigned MAX_NODES = 1024;
  localparam int LONG_HOLD = 300;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  int               fails_seen;
  int               words_pending;
  int               burst_left;
  logic             long_hold_req = 1'b0;
  logic             long_hold_done = 1'b0;

  lfls_in_if  req_ch ();
  lfls_out_if rsp_ch ();

  linked_free_list_stack #(
    .MAX_NODES(MAX_NODES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  lfls_result_checker #(
    .MAX_NODES(MAX_NODES)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fails_seen),
    .pending    (words_pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("[linked_free_list_stack] ERROR");
    $finish;
  end

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned k;
    k = $urandom_range(0, IDX_W-1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return NO_INDEX;
      2: return IDX_W'(1) << k;
      3: return ~(IDX_W'(1) << k);
      default: return $urandom;
    endcase
  endfunction

  // offer one word, hold it until taken, then maybe idle between bursts
  task automatic send_word(input logic op, input logic [IDX_W-1:0] idx);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.blk_idx <= idx;
    do @(posedge clk); while (!req_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(input int count, input int push_pct);
    repeat (count)
      send_word(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, pick_index());
  endtask

  // response back-pressure: patterns of random length, one long hold on request
  initial begin
    rx_pattern_t pattern;
    int          span;
    rsp_ch.ready <= 1'b0;
    forever begin
      pattern = rx_pattern_t'($urandom_range(0, 3));
      span = $urandom_range(4, 60);
      repeat (span) begin
        @(posedge clk);
        if (long_hold_req && !long_hold_done) begin
          rsp_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          long_hold_done = 1'b1;
        end else begin
          case (pattern)
            RX_OPEN:   rsp_ch.ready <= 1'b1;
            RX_HALF:   rsp_ch.ready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ch.ready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= CAP_RESET;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_PUSH;
    req_ch.blk_idx <= '0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pop on empty, field extremes, LIFO order, reuse of recycled nodes
    send_word(OP_POP, 32'h1234_5678);
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, NO_INDEX);
    send_word(OP_PUSH, 32'h5555_5555);
    send_word(OP_PUSH, 32'hAAAA_AAAA);
    repeat (5) send_word(OP_POP, '0);
    send_word(OP_PUSH, 32'h8000_0000);
    send_word(OP_PUSH, 32'h0000_0001);
    send_word(OP_POP, NO_INDEX);
    send_word(OP_PUSH, 32'hDEAD_BEEF);
    repeat (3) send_word(OP_POP, '0);

    // capacity below the bump pointer: only recycled nodes remain, then full
    write_capacity(CAP_W'(1));
    repeat (5) send_word(OP_PUSH, pick_index());
    repeat (5) send_word(OP_POP, '0);
    run_random(80, 55);

    write_capacity(CAP_W'(3));
    run_random(200, 55);

    // no fresh nodes at all
    write_capacity('0);
    run_random(100, 50);

    // capacity above range clamps to the node memory; fill it up
    write_capacity({CAP_W{1'b1}});
    long_hold_req = 1'b1;
    run_random(600, 96);
    wait_drained();
    run_random(600, 96);

    write_capacity(CAP_RESET);
    run_random(330, 30);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fails_seen == 0)
      $display("[linked_free_list_stack] OK");
    else
      $display("[linked_free_list_stack] ERROR");
    $finish;
  end

endmodule
